### rtl/rti_pkg.sv
// rti_pkg: shared widths, config register indexes and threshold reset value
// for the ray/triangle intersection block. No dependencies.
package rti_pkg;
  localparam int COORD_W_DEF = 16;
  localparam int THRESH_W    = 53;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int T_W         = 32;
  localparam int UV_W        = 17;
  localparam int FRAC_BITS   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X  = 3'd0,
    REG_ORG_Y  = 3'd1,
    REG_ORG_Z  = 3'd2,
    REG_DIR_X  = 3'd3,
    REG_DIR_Y  = 3'd4,
    REG_DIR_Z  = 3'd5,
    REG_THRESH = 3'd6,
    REG_NONE   = 3'd7
  } cfg_reg_t;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 53'd1678;
endpackage

### rtl/rti_div.sv
// rti_div: pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^16 / den) in OUT_W bits, all ones when it does not fit.
// Uses rti_pkg.
module rti_div #(
  parameter int NUM_W = 64,
  parameter int OUT_W = 49
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [NUM_W-1:0] in_den,
  output logic             out_vld,
  output logic [OUT_W-1:0] out_quo
);
  import rti_pkg::*;
  // one stage per quotient bit; dividend extended by FRAC_BITS zeros
  localparam int EXT_W = NUM_W + FRAC_BITS;
  localparam int STG   = OUT_W;
  localparam int TOP_W = EXT_W - OUT_W;

  logic [STG:0]            vld_r;
  logic [STG:0]            ovf_r;
  logic [NUM_W:0]          rem_r  [STG+1];
  logic [EXT_W-1:0]        dvd_r  [STG+1];
  logic [NUM_W-1:0]        den_r  [STG+1];
  logic [OUT_W-1:0]        quo_r  [STG+1];
  logic [EXT_W-1:0]        dvd_ext;

  always_comb begin
    dvd_ext  = {in_num, {FRAC_BITS{1'b0}}};
    vld_r[0] = in_vld;
    // bits above the quotient range seed the remainder; once they reach
    // den the quotient no longer fits in OUT_W bits
    rem_r[0] = (NUM_W+1)'(dvd_ext[EXT_W-1:OUT_W]);
    ovf_r[0] = NUM_W'(dvd_ext[EXT_W-1:OUT_W]) >= in_den;
    dvd_r[0] = dvd_ext << TOP_W;
    den_r[0] = in_den;
    quo_r[0] = '0;
  end

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [NUM_W+1:0] trial;
    logic [NUM_W:0]   shifted;
    always_comb begin
      shifted = {rem_r[s][NUM_W-1:0], dvd_r[s][EXT_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      ovf_r[s+1] <= ovf_r[s];
      dvd_r[s+1] <= dvd_r[s] << 1;
      den_r[s+1] <= den_r[s];
      if (!trial[NUM_W+1]) begin
        rem_r[s+1] <= trial[NUM_W:0];
        quo_r[s+1] <= {quo_r[s][OUT_W-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= shifted;
        quo_r[s+1] <= {quo_r[s][OUT_W-2:0], 1'b0};
      end
    end
  end

  assign out_vld = vld_r[STG];
  assign out_quo = ovf_r[STG] ? '1 : quo_r[STG];
endmodule

### rtl/ray_triangle_intersect_top.sv
// ray_triangle_intersect_top: Moller-Trumbore ray/triangle test, fixed point.
// Depends on rti_pkg and rti_div.
//
// One triangle per clock, one result per triangle. The pipeline has 5
// arithmetic stages plus 49 divider stages plus 1 output stage; the
// bit-per-stage divider for t sets the depth. busy is
// always low: the pipeline never stalls since the receiver cannot hold off
// results. The ray and det_threshold come from the cfg port; write them
// only while no item is in flight.
module ray_triangle_intersect_top #(
  parameter int COORD_WIDTH = rti_pkg::COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_c_z,
  input  logic                          in_no_cull,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rti_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic                          out_backface,
  output logic signed [rti_pkg::T_W-1:0] out_hit_t,
  output logic [rti_pkg::UV_W-1:0]      out_hit_u,
  output logic [rti_pkg::UV_W-1:0]      out_hit_v
);
  import rti_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = CW + 1;       // edges, T
  localparam int XW  = 2*EW + 1;     // cross products
  localparam int DW  = 64;           // det/u/v/qe, exact in 64 bits
  localparam int QW  = FRAC_BITS + 33; // quotient: 33 int + 16 frac
  localparam int DIV_LAT = QW;

  // ---------------- configuration ----------------
  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r, dir_x_r, dir_y_r, dir_z_r;
  logic [THRESH_W-1:0]  thr_r;
  logic                 cfg_wr;
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      dir_x_r <= '0; dir_y_r <= '0;
      dir_z_r <= CW'(256);
      thr_r   <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORG_X:  org_x_r <= cfg_data[CW-1:0];
        REG_ORG_Y:  org_y_r <= cfg_data[CW-1:0];
        REG_ORG_Z:  org_z_r <= cfg_data[CW-1:0];
        REG_DIR_X:  dir_x_r <= cfg_data[CW-1:0];
        REG_DIR_Y:  dir_y_r <= cfg_data[CW-1:0];
        REG_DIR_Z:  dir_z_r <= cfg_data[CW-1:0];
        REG_THRESH: thr_r   <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [DW-1:0] dx, dy, dz;
  assign dx = DW'(dir_x_r);
  assign dy = DW'(dir_y_r);
  assign dz = DW'(dir_z_r);

  // ---------------- stage 1: edges, T ----------------
  logic                 v1_r, two1_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, tx_r, ty_r, tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
    two1_r <= in_no_cull;
    e1x_r <= EW'(in_vertex_b_x) - EW'(in_vertex_a_x);
    e1y_r <= EW'(in_vertex_b_y) - EW'(in_vertex_a_y);
    e1z_r <= EW'(in_vertex_b_z) - EW'(in_vertex_a_z);
    e2x_r <= EW'(in_vertex_c_x) - EW'(in_vertex_a_x);
    e2y_r <= EW'(in_vertex_c_y) - EW'(in_vertex_a_y);
    e2z_r <= EW'(in_vertex_c_z) - EW'(in_vertex_a_z);
    tx_r  <= EW'(org_x_r) - EW'(in_vertex_a_x);
    ty_r  <= EW'(org_y_r) - EW'(in_vertex_a_y);
    tz_r  <= EW'(org_z_r) - EW'(in_vertex_a_z);
  end

  // ---------------- stage 2: normal N = E1 x E2 ----------------
  logic                 v2_r, two2_r;
  logic signed [EW-1:0] e1x2_r, e1y2_r, e1z2_r, e2x2_r, e2y2_r, e2z2_r;
  logic signed [EW-1:0] tx2_r, ty2_r, tz2_r;
  logic signed [XW-1:0] nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    two2_r <= two1_r;
    e1x2_r <= e1x_r; e1y2_r <= e1y_r; e1z2_r <= e1z_r;
    e2x2_r <= e2x_r; e2y2_r <= e2y_r; e2z2_r <= e2z_r;
    tx2_r <= tx_r; ty2_r <= ty_r; tz2_r <= tz_r;
    nx_r <= XW'(e1y_r) * XW'(e2z_r) - XW'(e1z_r) * XW'(e2y_r);
    ny_r <= XW'(e1z_r) * XW'(e2x_r) - XW'(e1x_r) * XW'(e2z_r);
    nz_r <= XW'(e1x_r) * XW'(e2y_r) - XW'(e1y_r) * XW'(e2x_r);
  end

  // ---------------- stage 3: N.dir, backface gate, edge swap ----------
  logic                 v3_r, back3_r, rej3_r;
  logic signed [EW-1:0] f1x_r, f1y_r, f1z_r, f2x_r, f2y_r, f2z_r;
  logic signed [EW-1:0] tx3_r, ty3_r, tz3_r;
  logic signed [DW-1:0] nd;
  logic                 back;

  always_comb begin
    nd   = DW'(nx_r) * dx + DW'(ny_r) * dy + DW'(nz_r) * dz;
    back = (nd > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    back3_r <= back;
    rej3_r  <= back & ~two2_r;
    tx3_r <= tx2_r; ty3_r <= ty2_r; tz3_r <= tz2_r;
    if (back) begin
      f1x_r <= e2x2_r; f1y_r <= e2y2_r; f1z_r <= e2z2_r;
      f2x_r <= e1x2_r; f2y_r <= e1y2_r; f2z_r <= e1z2_r;
    end else begin
      f1x_r <= e1x2_r; f1y_r <= e1y2_r; f1z_r <= e1z2_r;
      f2x_r <= e2x2_r; f2y_r <= e2y2_r; f2z_r <= e2z2_r;
    end
  end

  // ---------------- stage 4: P = D x E2, Q = T x E1 ----------------
  logic                 v4_r, back4_r, rej4_r;
  logic signed [EW-1:0] f1x4_r, f1y4_r, f1z4_r, f2x4_r, f2y4_r, f2z4_r;
  logic signed [EW-1:0] tx4_r, ty4_r, tz4_r;
  logic signed [XW-1:0] px_r, py_r, pz_r, qx_r, qy_r, qz_r;
  logic signed [XW-1:0] dxw, dyw, dzw;
  assign dxw = XW'(dir_x_r);
  assign dyw = XW'(dir_y_r);
  assign dzw = XW'(dir_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    back4_r <= back3_r;
    rej4_r  <= rej3_r;
    f1x4_r <= f1x_r; f1y4_r <= f1y_r; f1z4_r <= f1z_r;
    f2x4_r <= f2x_r; f2y4_r <= f2y_r; f2z4_r <= f2z_r;
    tx4_r <= tx3_r; ty4_r <= ty3_r; tz4_r <= tz3_r;
    px_r <= dyw * XW'(f2z_r) - dzw * XW'(f2y_r);
    py_r <= dzw * XW'(f2x_r) - dxw * XW'(f2z_r);
    pz_r <= dxw * XW'(f2y_r) - dyw * XW'(f2x_r);
    qx_r <= XW'(ty3_r) * XW'(f1z_r) - XW'(tz3_r) * XW'(f1y_r);
    qy_r <= XW'(tz3_r) * XW'(f1x_r) - XW'(tx3_r) * XW'(f1z_r);
    qz_r <= XW'(tx3_r) * XW'(f1y_r) - XW'(ty3_r) * XW'(f1x_r);
  end

  // ---------------- stage 5: det, u, v, Q.E2, bounds tests ----------
  logic                 v5_r, back5_r, hit5_r, neg5_r;
  logic [DW-1:0]        det5_r, u5_r, v5v_r, mag5_r;
  logic signed [DW-1:0] det, uu, vv, qe;
  logic                 miss;

  always_comb begin
    det = DW'(f1x4_r) * DW'(px_r) + DW'(f1y4_r) * DW'(py_r) + DW'(f1z4_r) * DW'(pz_r);
    uu  = DW'(tx4_r) * DW'(px_r) + DW'(ty4_r) * DW'(py_r) + DW'(tz4_r) * DW'(pz_r);
    vv  = DW'(qx_r) * dx + DW'(qy_r) * dy + DW'(qz_r) * dz;
    qe  = DW'(qx_r) * DW'(f2x4_r) + DW'(qy_r) * DW'(f2y4_r) + DW'(qz_r) * DW'(f2z4_r);
    miss = rej4_r | (det <= 0) | (DW'(det) < DW'(thr_r))
         | (uu < 0) | (uu > det) | (vv < 0) | ((uu + vv) > det);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    back5_r <= back4_r;
    hit5_r  <= ~miss;
    neg5_r  <= qe[DW-1];
    det5_r  <= miss ? DW'(1) : det;
    u5_r    <= uu;
    v5v_r   <= vv;
    mag5_r  <= qe[DW-1] ? -qe : qe;
  end

  // ---------------- dividers ----------------
  logic          dv_t, dv_u, dv_v;
  logic [QW-1:0] q_t, q_u, q_v;

  rti_div #(.NUM_W(DW), .OUT_W(QW)) u_div_t (
    .clk, .rst_n, .in_vld(v5_r), .in_num(mag5_r), .in_den(det5_r),
    .out_vld(dv_t), .out_quo(q_t));
  rti_div #(.NUM_W(DW), .OUT_W(QW)) u_div_u (
    .clk, .rst_n, .in_vld(v5_r), .in_num(u5_r), .in_den(det5_r),
    .out_vld(dv_u), .out_quo(q_u));
  rti_div #(.NUM_W(DW), .OUT_W(QW)) u_div_v (
    .clk, .rst_n, .in_vld(v5_r), .in_num(v5v_r), .in_den(det5_r),
    .out_vld(dv_v), .out_quo(q_v));

  // flags ride alongside the divider
  logic [DIV_LAT-1:0] hit_d_r, back_d_r, neg_d_r;
  always_ff @(posedge clk) begin
    hit_d_r  <= {hit_d_r[DIV_LAT-2:0], hit5_r};
    back_d_r <= {back_d_r[DIV_LAT-2:0], back5_r};
    neg_d_r  <= {neg_d_r[DIV_LAT-2:0], neg5_r};
  end

  // ---------------- output stage: saturate, zero on miss --------
  // divider reads all ones when t is too large; saturate to 32 bits
  logic [QW-1:0]         tq;
  logic signed [T_W-1:0] tval;
  logic                  hit_o;

  always_comb begin
    tq = q_t;
    if (neg_d_r[DIV_LAT-1]) begin
      if (tq >= QW'(64'h8000_0000)) tval = {1'b1, {(T_W-1){1'b0}}};
      else                          tval = -$signed(tq[T_W-1:0]);
    end else begin
      if (tq > QW'(64'h7FFF_FFFF))  tval = {1'b0, {(T_W-1){1'b1}}};
      else                          tval = tq[T_W-1:0];
    end
    hit_o = hit_d_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= dv_t & dv_u & dv_v;
    out_hit      <= hit_o;
    out_backface <= back_d_r[DIV_LAT-1];
    out_hit_t    <= hit_o ? tval : '0;
    out_hit_u    <= hit_o ? q_u[UV_W-1:0] : '0;
    out_hit_v    <= hit_o ? q_v[UV_W-1:0] : '0;
  end
endmodule
